// ===== hw/rtl/isort_pkg.sv =====
// Shared types and constants for the insertion sorter.
// No dependencies.
package isort_pkg;

   localparam int KEY_WIDTH = 32;

   typedef struct packed {
      logic insert;   // place the broadcast key into the chain
      logic shift;    // move every key one cell towards cell 0
   } cell_ctl_type;

endpackage

// ===== hw/rtl/isort_cell.sv =====
// One cell of the sorting chain: holds a single key and trades it with its neighbours.
// Depends on isort_pkg.
module isort_cell #(
   parameter int INDEX = 0,
   parameter int KW    = 32,
   parameter int CW    = 5
) (
   input  logic                      clock,
   input  isort_pkg::cell_ctl_type   ctl,
   input  logic [CW-1:0]             fill,
   input  logic [KW-1:0]             new_key,
   input  logic                      left_keep,
   input  logic [KW-1:0]             left_key,
   input  logic [KW-1:0]             right_key,
   output logic [KW-1:0]             key_ff,
   output logic                      keep
);

   logic [KW-1:0] key_in;
   logic          occupied;

   assign occupied = fill > CW'(INDEX);
   // Hold the stored key when the cell is occupied and its key is not greater than the new one.
   assign keep     = occupied && !(key_ff > new_key);

   always_comb begin
      key_in = key_ff;
      if (ctl.shift) begin
         key_in = right_key;
      end else if (ctl.insert && !keep) begin
         key_in = left_keep ? new_key : left_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ===== hw/rtl/insertion_sorter.sv =====
// Insertion sorter built from isort_pkg and a chain of CAPACITY isort_cell instances.
// Each key is inserted in the cycle it is accepted, or discarded and flagged as overflow
// when the list is full; busy stays low between keys. After a key flagged last, busy is
// high while the chain shifts one key a cycle into the result register until all held
// keys are out; the first result passes the state and result registers, then one per cycle follows.
// Synchronous reset empties the list and clears the overflow flag; the receiver cannot stall.
module insertion_sorter #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [isort_pkg::KEY_WIDTH-1:0]   req_key,
   input  logic                              req_last,
   output logic                              rsp_valid,
   output logic [isort_pkg::KEY_WIDTH-1:0]   rsp_sorted_key,
   output logic                              rsp_final_res,
   output logic                              rsp_overflow
);

   localparam int KW = (KEY_BITS < isort_pkg::KEY_WIDTH) ? KEY_BITS : isort_pkg::KEY_WIDTH;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic                          dropped_ff, dropped_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [isort_pkg::KEY_WIDTH-1:0] rsp_key_ff, rsp_key_in;
   logic                          rsp_final_ff, rsp_final_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;

   isort_pkg::cell_ctl_type       ctl;
   logic [KW-1:0]                 new_key;
   logic [KW-1:0]                 cell_key [CAPACITY];
   logic                          cell_keep [CAPACITY];
   logic                          accept;
   logic                          full;

   assign new_key = req_key[KW-1:0];
   assign accept  = start && (state_ff == ST_IDLE);
   assign full    = fill_ff == CW'(CAPACITY);

   assign ctl.insert = accept && !full;
   assign ctl.shift  = state_ff == ST_DRAIN;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          left_keep;
      logic [KW-1:0] left_key;
      logic [KW-1:0] right_key;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_key  = new_key;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_key  = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = '0;
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      isort_cell #(
         .INDEX (i),
         .KW    (KW),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .fill      (fill_ff),
         .new_key   (new_key),
         .left_keep (left_keep),
         .left_key  (left_key),
         .right_key (right_key),
         .key_ff    (cell_key[i]),
         .keep      (cell_keep[i])
      );
   end

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = 1'b0;
      rsp_key_in      = rsp_key_ff;
      rsp_final_in    = 1'b0;
      rsp_overflow_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // Emit cell 0 and advance the chain by one.
            rsp_valid_in    = 1'b1;
            rsp_key_in      = isort_pkg::KEY_WIDTH'(cell_key[0]);
            rsp_final_in    = fill_ff == CW'(1);
            rsp_overflow_in = dropped_ff;
            fill_in         = fill_ff - CW'(1);
            if (fill_ff == CW'(1)) begin
               state_in   = ST_IDLE;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_ff         <= '0;
         dropped_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_final_ff    <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fill_ff         <= fill_in;
         dropped_ff      <= dropped_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_final_ff    <= rsp_final_in;
         rsp_overflow_ff <= rsp_overflow_in;
      end
      rsp_key_ff <= rsp_key_in;
   end

   assign busy           = state_ff == ST_DRAIN;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sorted_key = rsp_key_ff;
   assign rsp_final_res  = rsp_final_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (fill_ff != '0))
      else $error("drain with empty list");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (busy && !rsp_valid))
      else $error("last transaction did not start the drain");

   a_final_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_res) |-> (!busy && fill_ff == '0 && !dropped_ff))
      else $error("final result while list not emptied");

endmodule
